[hdl/cmtm_pkg.sv]
package cmtm_pkg;

  localparam int ID_W   = 29;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;
  localparam int HITS_W = 12;
  localparam int CMD_W  = 3;

  localparam int EXPECT_SLOTS_DEF = 12;
  localparam int SUB_SLOTS_DEF    = 12;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ARM   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_ALLOC    = 5'b00010,
    S_SCAN_EXP = 5'b00100,
    S_SCAN_SUB = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  // result of the shared compare unit
  typedef struct packed {
    logic id_eq;
    logic expired;
  } cmp_res_t;

endpackage

[hdl/cmtm_ram.sv]
module cmtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

[hdl/cmtm_cmp_unit.sv]
module cmtm_cmp_unit (
  input  logic [cmtm_pkg::ID_W-1:0]   id_a,
  input  logic [cmtm_pkg::ID_W-1:0]   id_b,
  input  logic [cmtm_pkg::TIME_W-1:0] now,
  input  logic [cmtm_pkg::TIME_W-1:0] last,
  input  logic [cmtm_pkg::TIME_W-1:0] timeout,
  output cmtm_pkg::cmp_res_t          res
);

  import cmtm_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // wrapping difference, then one compare against the timeout
  assign elapsed     = now - last;
  assign res.id_eq   = (id_a == id_b);
  assign res.expired = (elapsed > timeout);

endmodule

[hdl/can_message_timeout_monitor.sv]
// channel  | direction | signals
// ---------+-----------+-----------------------------------------------------------
// in_      | input     | valid/ready, command, frame_id, time_ms, allowed_ms
// out_     | output    | valid/ready, status, subscriber_hits, id_missing, counts
//
// one command at a time; a shared id/time comparator walks the slot tables
// arm and subscribe search the flags for the first free slot
// tick and query scan the expectation table; frame scans it, then the subscriber table
// the slot memories have one read port each and a registered read
// rst_n (synchronous) clears armed/missing/used flags, time and counters at once
// a waiting result does not block the next transfer in; a stalled out_ holds in done
module can_message_timeout_monitor #(
  parameter int EXPECT_SLOTS = cmtm_pkg::EXPECT_SLOTS_DEF,
  parameter int SUB_SLOTS    = cmtm_pkg::SUB_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cmtm_pkg::CMD_W-1:0]   in_command,
  input  logic [cmtm_pkg::ID_W-1:0]    in_frame_id,
  input  logic [cmtm_pkg::TIME_W-1:0]  in_time_ms,
  input  logic [cmtm_pkg::TIME_W-1:0]  in_allowed_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [cmtm_pkg::HITS_W-1:0]  out_subscriber_hits,
  output logic                         out_id_missing,
  output logic [cmtm_pkg::CNT_W-1:0]   out_rx_count,
  output logic [cmtm_pkg::CNT_W-1:0]   out_unexpected_count,
  output logic [cmtm_pkg::CNT_W-1:0]   out_missing_count
);

  import cmtm_pkg::*;

  localparam int EAW = (EXPECT_SLOTS > 1) ? $clog2(EXPECT_SLOTS) : 1;
  localparam int SAW = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
  localparam int IW  = (EAW > SAW) ? EAW : SAW;
  // expectation word: id, timeout, last seen
  localparam int EW  = ID_W + 2 * TIME_W;

  localparam logic [IW-1:0] LAST_E = IW'(EXPECT_SLOTS - 1);
  localparam logic [IW-1:0] LAST_S = IW'(SUB_SLOTS - 1);

  // sequencer and flags
  state_t                  state_r, state_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;        // read issue index
  logic                    issue_r, issue_nxt;
  logic [IW-1:0]           idx_d_r, idx_d_nxt;    // index of data coming out of the rams
  logic                    vld_d_r, vld_d_nxt;
  logic [EXPECT_SLOTS-1:0] armed_r, armed_nxt;
  logic [EXPECT_SLOTS-1:0] missing_r, missing_nxt;
  logic [SUB_SLOTS-1:0]    used_r, used_nxt;
  logic [TIME_W-1:0]       cur_time_r, cur_time_nxt;
  logic [CNT_W-1:0]        rx_cnt_r, rx_cnt_nxt;
  logic [CNT_W-1:0]        unexp_cnt_r, unexp_cnt_nxt;
  logic [CNT_W-1:0]        miss_cnt_r, miss_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // per-command working values
  logic                    status_r, status_nxt;
  logic [HITS_W-1:0]       hits_r, hits_nxt;
  logic                    qmiss_r, qmiss_nxt;
  logic                    found_r, found_nxt;
  logic                    known_r, known_nxt;

  // latched command
  logic [CMD_W-1:0]        cmd_r;
  logic [ID_W-1:0]         id_r;
  logic [TIME_W-1:0]       time_r;
  logic [TIME_W-1:0]       tmo_r;

  // result register
  logic                    o_status_r;
  logic [HITS_W-1:0]       o_hits_r;
  logic                    o_qmiss_r;
  logic [CNT_W-1:0]        o_rx_r;
  logic [CNT_W-1:0]        o_unexp_r;
  logic [CNT_W-1:0]        o_miss_r;
  logic                    o_load;

  // memory ports
  logic                    exp_we;
  logic [EAW-1:0]          exp_wa;
  logic [EW-1:0]           exp_wd;
  logic [EW-1:0]           exp_rd;
  logic                    sub_we;
  logic [SAW-1:0]          sub_wa;
  logic [ID_W-1:0]         sub_rd;

  logic [ID_W-1:0]         exp_rd_id;
  logic [TIME_W-1:0]       exp_rd_tmo;
  logic [TIME_W-1:0]       exp_rd_last;
  logic [ID_W-1:0]         cmp_id_b;
  cmp_res_t                cmp;

  logic                    in_xfer;
  logic                    last_issue;
  logic [EAW-1:0]          e_slot;
  logic [EAW-1:0]          a_eslot;
  logic [SAW-1:0]          a_sslot;
  logic                    slot_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign {exp_rd_id, exp_rd_tmo, exp_rd_last} = exp_rd;

  assign e_slot  = idx_d_r[EAW-1:0];
  assign a_eslot = idx_r[EAW-1:0];
  assign a_sslot = idx_r[SAW-1:0];

  // one comparator serves both tables: subscriber ids during the second pass
  assign cmp_id_b = (state_r == S_SCAN_SUB) ? sub_rd : exp_rd_id;

  cmtm_cmp_unit u_cmp (
    .id_a    (id_r),
    .id_b    (cmp_id_b),
    .now     (time_r),
    .last    (exp_rd_last),
    .timeout (exp_rd_tmo),
    .res     (cmp)
  );

  cmtm_ram #(
    .WIDTH (EW),
    .DEPTH (EXPECT_SLOTS)
  ) u_exp_ram (
    .clk (clk),
    .we  (exp_we),
    .wa  (exp_wa),
    .wd  (exp_wd),
    .ra  (idx_r[EAW-1:0]),
    .rd  (exp_rd)
  );

  cmtm_ram #(
    .WIDTH (ID_W),
    .DEPTH (SUB_SLOTS)
  ) u_sub_ram (
    .clk (clk),
    .we  (sub_we),
    .wa  (sub_wa),
    .wd  (id_r),
    .ra  (idx_r[SAW-1:0]),
    .rd  (sub_rd)
  );

  // free-slot test for the allocation walk
  always_comb begin
    if (cmd_r == CMD_ARM) begin
      slot_free = !armed_r[a_eslot];
    end else begin
      slot_free = !used_r[a_sslot];
    end
  end

  // last read of the current pass
  always_comb begin
    if (state_r == S_SCAN_SUB) begin
      last_issue = (idx_r == LAST_S);
    end else begin
      last_issue = (idx_r == LAST_E);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    issue_nxt     = issue_r;
    idx_d_nxt     = idx_r;
    vld_d_nxt     = 1'b0;
    armed_nxt     = armed_r;
    missing_nxt   = missing_r;
    used_nxt      = used_r;
    cur_time_nxt  = cur_time_r;
    rx_cnt_nxt    = rx_cnt_r;
    unexp_cnt_nxt = unexp_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    hits_nxt      = hits_r;
    qmiss_nxt     = qmiss_r;
    found_nxt     = found_r;
    known_nxt     = known_r;
    o_load        = 1'b0;
    exp_we        = 1'b0;
    exp_wa        = a_eslot;
    exp_wd        = {id_r, tmo_r, cur_time_r};
    sub_we        = 1'b0;
    sub_wa        = a_sslot;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt = 1'b0;
          hits_nxt   = '0;
          qmiss_nxt  = 1'b0;
          found_nxt  = 1'b0;
          known_nxt  = 1'b0;
          idx_nxt    = '0;
          issue_nxt  = 1'b1;
          if (in_command == CMD_TICK) begin
            cur_time_nxt = in_time_ms;
          end
          if (in_command == CMD_ARM || in_command == CMD_SUB) begin
            state_nxt = S_ALLOC;
          end else if (in_command == CMD_FRAME || in_command == CMD_TICK ||
                       in_command == CMD_QUERY) begin
            state_nxt = S_SCAN_EXP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // walk the flags for the lowest free slot
      S_ALLOC: begin
        if (slot_free) begin
          if (cmd_r == CMD_ARM) begin
            exp_we               = 1'b1;
            armed_nxt[a_eslot]   = 1'b1;
            missing_nxt[a_eslot] = 1'b0;
          end else begin
            sub_we            = 1'b1;
            used_nxt[a_sslot] = 1'b1;
          end
          state_nxt = S_DONE;
        end else if ((cmd_r == CMD_ARM && idx_r == LAST_E) ||
                     (cmd_r != CMD_ARM && idx_r == LAST_S)) begin
          status_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_SCAN_EXP: begin
        vld_d_nxt = issue_r;
        if (issue_r) begin
          if (last_issue) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        if (vld_d_r && armed_r[e_slot]) begin
          unique case (cmd_r)
            CMD_FRAME: begin
              if (cmp.id_eq) begin
                // refresh last seen, keep id and timeout
                exp_we              = 1'b1;
                exp_wa              = e_slot;
                exp_wd              = {exp_rd_id, exp_rd_tmo, cur_time_r};
                missing_nxt[e_slot] = 1'b0;
                known_nxt           = 1'b1;
              end
            end
            CMD_TICK: begin
              if (cmp.expired) begin
                if (!missing_r[e_slot]) begin
                  miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
                end
                missing_nxt[e_slot] = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (cmp.id_eq && !found_r) begin
                qmiss_nxt = missing_r[e_slot];
                found_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if (vld_d_r && idx_d_r == LAST_E) begin
          if (cmd_r == CMD_FRAME) begin
            idx_nxt   = '0;
            issue_nxt = 1'b1;
            state_nxt = S_SCAN_SUB;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN_SUB: begin
        vld_d_nxt = issue_r;
        if (issue_r) begin
          if (last_issue) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        if (vld_d_r && used_r[idx_d_r[SAW-1:0]] && cmp.id_eq) begin
          // slots past the hit mask still count as known
          known_nxt = 1'b1;
          hits_nxt  = hits_r | (HITS_W'(1) << idx_d_r);
        end
        if (vld_d_r && idx_d_r == LAST_S) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          if (cmd_r == CMD_FRAME) begin
            rx_cnt_nxt = rx_cnt_r + CNT_W'(1);
            if (!known_r) begin
              unexp_cnt_nxt = unexp_cnt_r + CNT_W'(1);
            end
          end
          o_load        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      idx_d_r     <= '0;
      vld_d_r     <= 1'b0;
      armed_r     <= '0;
      missing_r   <= '0;
      used_r      <= '0;
      cur_time_r  <= '0;
      rx_cnt_r    <= '0;
      unexp_cnt_r <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      status_r    <= 1'b0;
      hits_r      <= '0;
      qmiss_r     <= 1'b0;
      found_r     <= 1'b0;
      known_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      issue_r     <= issue_nxt;
      idx_d_r     <= idx_d_nxt;
      vld_d_r     <= vld_d_nxt;
      armed_r     <= armed_nxt;
      missing_r   <= missing_nxt;
      used_r      <= used_nxt;
      cur_time_r  <= cur_time_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      unexp_cnt_r <= unexp_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      hits_r      <= hits_nxt;
      qmiss_r     <= qmiss_nxt;
      found_r     <= found_nxt;
      known_r     <= known_nxt;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= in_command;
      id_r   <= in_frame_id;
      time_r <= in_time_ms;
      tmo_r  <= in_allowed_ms;
    end
    if (o_load) begin
      o_status_r <= status_r;
      o_hits_r   <= hits_r;
      o_qmiss_r  <= qmiss_r;
      o_rx_r     <= rx_cnt_nxt;
      o_unexp_r  <= unexp_cnt_nxt;
      o_miss_r   <= miss_cnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_subscriber_hits  = o_hits_r;
  assign out_id_missing       = o_qmiss_r;
  assign out_rx_count         = o_rx_r;
  assign out_unexpected_count = o_unexp_r;
  assign out_missing_count    = o_miss_r;

endmodule

[bench/can_message_timeout_monitor_tb.sv]
`timescale 1ns / 100ps

module can_message_timeout_monitor_tb;
  import cmtm_pkg::*;

  // table sizes of the instance under test
  localparam int N_WATCH = EXPECT_SLOTS_DEF;
  localparam int N_SUBS  = SUB_SLOTS_DEF;

  // command codes with no function
  localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

  // ids and timeouts used to fill the tables in the directed part
  localparam logic [ID_W-1:0]   ID_MAX      = '1;
  localparam logic [ID_W-1:0]   ARM_ID_BASE = 29'h100;
  localparam logic [ID_W-1:0]   SUB_ID_BASE = 29'h104;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam logic [TIME_W-1:0] TMO_STEP    = 32'd40;
  localparam int                FILL_COUNT  = 10;

  // run length and limits
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int MAX_REPORTS  = 200;

  typedef struct packed {
    logic              status;
    logic [HITS_W-1:0] hits;
    logic              id_missing;
    logic [CNT_W-1:0]  rx;
    logic [CNT_W-1:0]  unexpected;
    logic [CNT_W-1:0]  missing;
  } sup_result_t;

  // one row of directed stimulus; rep > 1 walks id up by one and scales the timeout
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] tmo;
    logic [7:0]        rep;
    logic              typed;
    sup_result_t       want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command;
  logic [ID_W-1:0]   in_frame_id;
  logic [TIME_W-1:0] in_time_ms;
  logic [TIME_W-1:0] in_allowed_ms;
  logic              out_valid;
  logic              out_ready;
  logic              out_status;
  logic [HITS_W-1:0] out_subscriber_hits;
  logic              out_id_missing;
  logic [CNT_W-1:0]  out_rx_count;
  logic [CNT_W-1:0]  out_unexpected_count;
  logic [CNT_W-1:0]  out_missing_count;

  can_message_timeout_monitor #(
    .EXPECT_SLOTS(N_WATCH),
    .SUB_SLOTS   (N_SUBS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_frame_id         (in_frame_id),
    .in_time_ms          (in_time_ms),
    .in_allowed_ms       (in_allowed_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_subscriber_hits (out_subscriber_hits),
    .out_id_missing      (out_id_missing),
    .out_rx_count        (out_rx_count),
    .out_unexpected_count(out_unexpected_count),
    .out_missing_count   (out_missing_count)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // supervisor state as the testbench sees it
  logic [ID_W-1:0]   watch_id    [N_WATCH];
  logic [TIME_W-1:0] watch_tmo   [N_WATCH];
  logic [TIME_W-1:0] watch_seen  [N_WATCH];
  logic              watch_armed [N_WATCH];
  logic              watch_late  [N_WATCH];
  logic [ID_W-1:0]   subs_id     [N_SUBS];
  logic              subs_used   [N_SUBS];
  logic [TIME_W-1:0] now_ms;
  logic [CNT_W-1:0]  rx_total;
  logic [CNT_W-1:0]  unexp_total;
  logic [CNT_W-1:0]  late_total;

  sup_result_t pending_results[$];
  stim_row_t   stim_table[$];

  int mismatches;
  int results_seen;
  int n_items;
  int n_frames;
  int n_ticks;
  int n_queries;
  int burst_left;

  task automatic clear_supervisor();
    for (int i = 0; i < N_WATCH; i++) begin
      watch_id[i]    = '0;
      watch_tmo[i]   = '0;
      watch_seen[i]  = '0;
      watch_armed[i] = 1'b0;
      watch_late[i]  = 1'b0;
    end
    for (int i = 0; i < N_SUBS; i++) begin
      subs_id[i]   = '0;
      subs_used[i] = 1'b0;
    end
    now_ms      = '0;
    rx_total    = '0;
    unexp_total = '0;
    late_total  = '0;
  endtask

  // advance the supervisor by one command and return the result it gives
  task automatic predict_supervisor(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] tmo,
                                    output sup_result_t r);
    logic              placed;
    logic              known;
    logic [TIME_W-1:0] silence;
    r      = '0;
    placed = 1'b0;
    known  = 1'b0;
    case (cmd)
      CMD_ARM: begin
        // lowest free slot, stamped with the time of the last tick
        for (int i = 0; i < N_WATCH; i++) begin
          if (!placed && !watch_armed[i]) begin
            watch_id[i]    = id;
            watch_tmo[i]   = tmo;
            watch_seen[i]  = now_ms;
            watch_armed[i] = 1'b1;
            watch_late[i]  = 1'b0;
            placed         = 1'b1;
          end
        end
        r.status = !placed;
      end
      CMD_SUB: begin
        for (int i = 0; i < N_SUBS; i++) begin
          if (!placed && !subs_used[i]) begin
            subs_id[i]   = id;
            subs_used[i] = 1'b1;
            placed       = 1'b1;
          end
        end
        r.status = !placed;
      end
      CMD_FRAME: begin
        rx_total = rx_total + 1'b1;
        // every matching slot is refreshed, duplicates included
        for (int i = 0; i < N_WATCH; i++) begin
          if (watch_armed[i] && watch_id[i] == id) begin
            watch_seen[i] = now_ms;
            watch_late[i] = 1'b0;
            known         = 1'b1;
          end
        end
        for (int i = 0; i < N_SUBS; i++) begin
          if (subs_used[i] && subs_id[i] == id) begin
            if (i < HITS_W) r.hits[i] = 1'b1;
            known = 1'b1;
          end
        end
        if (!known) unexp_total = unexp_total + 1'b1;
      end
      CMD_TICK: begin
        now_ms = t;
        // wrapping difference; only fresh transitions are counted
        for (int i = 0; i < N_WATCH; i++) begin
          silence = t - watch_seen[i];
          if (watch_armed[i] && silence > watch_tmo[i]) begin
            if (!watch_late[i]) late_total = late_total + 1'b1;
            watch_late[i] = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < N_WATCH; i++) begin
          if (!placed && watch_armed[i] && watch_id[i] == id) begin
            r.id_missing = watch_late[i];
            placed       = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.rx         = rx_total;
    r.unexpected = unexp_total;
    r.missing    = late_total;
  endtask

  function automatic sup_result_t make_result(logic status, logic [HITS_W-1:0] hits,
                                              logic miss, logic [CNT_W-1:0] rx,
                                              logic [CNT_W-1:0] unx, logic [CNT_W-1:0] mis);
    sup_result_t r;
    r.status     = status;
    r.hits       = hits;
    r.id_missing = miss;
    r.rx         = rx;
    r.unexpected = unx;
    r.missing    = mis;
    return r;
  endfunction

  task automatic add_row(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                         logic [TIME_W-1:0] tmo, int rep, logic typed, sup_result_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.id    = id;
    row.t     = t;
    row.tmo   = tmo;
    row.rep   = 8'(rep);
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // mostly ids that live in the tables, some extremes, some noise
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return ARM_ID_BASE + ID_W'($urandom_range(0, 13));
      7:                   return $urandom_range(0, 1) ? ID_MAX : '0;
      default:             return ID_W'($urandom);
    endcase
  endfunction

  task automatic random_item(output logic [CMD_W-1:0] cmd, output logic [ID_W-1:0] id,
                             output logic [TIME_W-1:0] t, output logic [TIME_W-1:0] tmo);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    id  = pick_id();
    t   = TIME_W'($urandom);
    tmo = TIME_W'($urandom);
    if (sel < 40) begin
      cmd = CMD_FRAME;
    end else if (sel < 70) begin
      cmd = CMD_TICK;
      // small steps keep slots near their timeouts; rare jumps and wraps
      case ($urandom_range(0, 19))
        0:       t = TIME_W'($urandom);
        1, 2:    t = now_ms + TIME_W'($urandom_range(0, 2000));
        default: t = now_ms + TIME_W'($urandom_range(0, 60));
      endcase
    end else if (sel < 88) begin
      cmd = CMD_QUERY;
    end else if (sel < 93) begin
      cmd = CMD_ARM;
    end else if (sel < 96) begin
      cmd = CMD_SUB;
    end else begin
      cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    end
  endtask

  // offer one command; bursts of random length with random gaps between them
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                           logic [TIME_W-1:0] tmo, logic typed, sup_result_t want);
    int          gap;
    sup_result_t pred;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 40);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_frame_id   <= id;
    in_time_ms    <= t;
    in_allowed_ms <= tmo;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge
    predict_supervisor(cmd, id, t, tmo, pred);
    pending_results.push_back(typed ? want : pred);
    n_items++;
    if (cmd == CMD_FRAME) n_frames++;
    if (cmd == CMD_TICK)  n_ticks++;
    if (cmd == CMD_QUERY) n_queries++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result side: compare each transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    sup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_subscriber_hits !== want.hits)
          report_mismatch("subscriber_hits", out_subscriber_hits, want.hits);
        if (out_id_missing !== want.id_missing)
          report_mismatch("id_missing", out_id_missing, want.id_missing);
        if (out_rx_count !== want.rx)
          report_mismatch("rx_count", out_rx_count, want.rx);
        if (out_unexpected_count !== want.unexpected)
          report_mismatch("unexpected_count", out_unexpected_count, want.unexpected);
        if (out_missing_count !== want.missing)
          report_mismatch("missing_count", out_missing_count, want.missing);
      end
    end
  end

  // receiver: changing stall modes, plus one long hold-off to back up the input
  initial begin : result_sink
    int mode;
    int phase_left;
    int cyc;
    bit held;
    out_ready  = 1'b0;
    mode       = 0;
    phase_left = 0;
    cyc        = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(50, 300);
      end
      phase_left--;
      cyc++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((cyc % 7) < 4);
      endcase
    end
  end

  // watchdog: cycles in which neither channel moves a transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] tmo;
    stim_row_t         row;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_QUERY;
    in_frame_id   = '0;
    in_time_ms    = '0;
    in_allowed_ms = '0;
    mismatches    = 0;
    results_seen  = 0;
    n_items       = 0;
    n_frames      = 0;
    n_ticks       = 0;
    n_queries     = 0;
    burst_left    = 0;
    clear_supervisor();

    // empty block answers zero everywhere
    add_row(CMD_QUERY, '0, '0, '0, 1, 1'b1, make_result(0, 0, 0, 0, 0, 0));
    // unused codes leave everything alone
    add_row(CMD_RSVD_LO, ID_MAX, TIME_MAX, TIME_MAX, 1, 1'b1, make_result(0, 0, 0, 0, 0, 0));
    add_row(CMD_RSVD_HI, ID_MAX, TIME_MAX, TIME_MAX, 1, 1'b1, make_result(0, 0, 0, 0, 0, 0));
    // frame with empty tables is unexpected
    add_row(CMD_FRAME, ID_MAX, '0, '0, 1, 1'b1, make_result(0, 0, 0, 1, 1, 0));
    // timeout extremes on the id extremes
    add_row(CMD_ARM, ID_MAX, '0, '0, 1, 1'b1, make_result(0, 0, 0, 1, 1, 0));
    add_row(CMD_ARM, '0, '0, TIME_MAX, 1, 1'b1, make_result(0, 0, 0, 1, 1, 0));
    // same subscriber twice takes two slots
    add_row(CMD_SUB, ID_MAX, '0, '0, 1, 1'b1, make_result(0, 0, 0, 1, 1, 0));
    add_row(CMD_SUB, ID_MAX, '0, '0, 1, 1'b1, make_result(0, 0, 0, 1, 1, 0));
    add_row(CMD_FRAME, ID_MAX, '0, '0, 1, 1'b0, '0);
    // zero timeout expires on the first tick, max timeout never does
    add_row(CMD_TICK, '0, 32'd1, '0, 1, 1'b0, '0);
    add_row(CMD_QUERY, ID_MAX, '0, '0, 1, 1'b0, '0);
    add_row(CMD_TICK, '0, TIME_MAX, '0, 1, 1'b0, '0);
    add_row(CMD_FRAME, ID_MAX, '0, '0, 1, 1'b0, '0);
    // time wraps through zero
    add_row(CMD_TICK, '0, '0, '0, 1, 1'b0, '0);
    add_row(CMD_QUERY, ID_MAX, '0, '0, 1, 1'b0, '0);
    add_row(CMD_FRAME, '0, '0, '0, 1, 1'b0, '0);
    // fill both tables, then the full-table status
    add_row(CMD_ARM, ARM_ID_BASE, '0, TMO_STEP, FILL_COUNT, 1'b0, '0);
    add_row(CMD_ARM, 29'h1234, '0, 32'd5, 1, 1'b1, make_result(1, 0, 0, 4, 1, 2));
    add_row(CMD_SUB, SUB_ID_BASE, '0, '0, FILL_COUNT, 1'b0, '0);
    add_row(CMD_SUB, '0, '0, '0, 1, 1'b1, make_result(1, 0, 0, 4, 1, 2));
    add_row(CMD_FRAME, 29'h1FFFFFFE, '0, '0, 1, 1'b0, '0);
    add_row(CMD_QUERY, 29'h1FFFFFFE, '0, '0, 1, 1'b0, '0);
    add_row(CMD_FRAME, SUB_ID_BASE + ID_W'(FILL_COUNT - 1), '0, '0, 1, 1'b0, '0);
    add_row(CMD_RSVD_MID, '0, '0, '0, 1, 1'b0, '0);

    // single reset at the start
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[r]) begin
      row = stim_table[r];
      for (int k = 0; k < int'(row.rep); k++)
        send_item(row.cmd, row.id + ID_W'(k), row.t, row.tmo * TIME_W'(k + 1), row.typed,
                  row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      random_item(cmd, id, t, tmo);
      send_item(cmd, id, t, tmo, 1'b0, '0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give a late stray result time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d frames, %0d ticks, %0d queries, %0d results checked",
             n_items, n_frames, n_ticks, n_queries, results_seen);
    $display("reached %0d missing transitions and %0d unexpected frames, %0d mismatches",
             late_total, unexp_total, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
